// File: rtl/mted_pkg.sv
// Package with the types, constants and register codes of the multitap echo delay.
`timescale 1ns / 1ps

package mted_pkg;

    localparam int DEPTH      = 4096;
    localparam int ADDR_W     = 12;
    localparam int NUM_TAPS   = 4;
    localparam int TAP_W      = 2;
    localparam int NUM_GAINS  = 5;
    localparam int GSEL_W     = 3;
    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 24;
    localparam int PROD_W     = 48;
    localparam int ACC_W      = 50;
    localparam int OUT_SHIFT  = 22;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 48;
    localparam int STEP_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_GAIN_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_DELAYS = 3'd5;

    localparam logic [ADDR_W-1:0] WR_IDX_RESET = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(DEPTH - 1);

    localparam logic signed [GAIN_W-1:0] GAIN_RESET [NUM_GAINS] = '{
        24'sd4194304, 24'sd6291456, 24'sd2097152, 24'sd1048576, 24'sd524288
    };
    localparam logic [ADDR_W-1:0] DELAY_RESET [NUM_TAPS] = '{
        12'd1024, 12'd1536, 12'd2560, 12'd3072
    };

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              capture;
        logic              wr_we;
        logic              rd_en;
        logic [TAP_W-1:0]  tap;
        logic              mul_en;
        logic              mul_src_in;
        logic [GSEL_W-1:0] gain_sel;
        logic              acc_load;
        logic              acc_add;
        logic              res_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
    } t_stat;

endpackage

// File: rtl/mted_dp.sv
// Datapath of the echo: delay line memory, registers, multiplier, accumulator and saturation.
`timescale 1ns / 1ps

module mted_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mted_pkg::t_cmd                   i_cmd,
    output mted_pkg::t_stat                  o_stat,
    input  logic signed [mted_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                             i_cfg_we,
    input  logic [mted_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mted_pkg::CFG_W-1:0]       i_cfg_data,
    output logic signed [mted_pkg::SAMPLE_W-1:0] o_sample_out
);
    import mted_pkg::*;

    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [GAIN_W-1:0]   r_gain [NUM_GAINS];
    logic [ADDR_W-1:0]          r_delay [NUM_TAPS];
    logic [ADDR_W-1:0]          r_wr_idx;
    logic [ADDR_W-1:0]          r_cur_w;
    logic [ADDR_W-1:0]          r_clr_addr;
    logic                       r_clr_done;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_result;

    logic [ADDR_W-1:0]          n_addr;
    logic                       n_mem_we;
    logic signed [SAMPLE_W-1:0] n_wdata;
    logic signed [SAMPLE_W-1:0] n_mul_a;
    logic signed [ACC_W-1:0]    n_prod_half;
    logic signed [ACC_W-OUT_SHIFT-1:0] n_scaled;
    logic signed [SAMPLE_W-1:0] n_sat;

    always_comb begin
        n_mem_we = 1'b0;
        n_wdata  = r_sample;
        n_addr   = r_cur_w - r_delay[i_cmd.tap];
        if (!r_clr_done) begin
            n_mem_we = 1'b1;
            n_wdata  = '0;
            n_addr   = r_clr_addr;
        end else if (i_cmd.wr_we) begin
            n_mem_we = 1'b1;
            n_addr   = r_wr_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_mem_we) begin
            r_mem[n_addr] <= n_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[n_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
            r_wr_idx   <= WR_IDX_RESET;
            r_cur_w    <= '0;
        end else begin
            if (!r_clr_done) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    r_clr_done <= 1'b1;
                end
            end
            if (i_cmd.wr_we) begin
                r_cur_w  <= r_wr_idx;
                r_wr_idx <= r_wr_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_GAINS; k++) begin
                r_gain[k] <= GAIN_RESET[k];
            end
            for (int k = 0; k < NUM_TAPS; k++) begin
                r_delay[k] <= DELAY_RESET[k];
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index <= REG_TAP_GAIN_3) begin
                r_gain[i_cfg_index] <= i_cfg_data[GAIN_W-1:0];
            end else if (i_cfg_index == REG_TAP_DELAYS) begin
                for (int k = 0; k < NUM_TAPS; k++) begin
                    r_delay[k] <= i_cfg_data[k*ADDR_W +: ADDR_W];
                end
            end
        end
    end

    assign n_mul_a     = i_cmd.mul_src_in ? r_sample : r_rd_data;
    assign n_prod_half = ACC_W'(r_prod >>> 1);
    assign n_scaled    = r_acc[ACC_W-1:OUT_SHIFT];

    always_comb begin
        if (n_scaled > ($bits(n_scaled))'(SAMPLE_MAX)) begin
            n_sat = SAMPLE_MAX;
        end else if (n_scaled < ($bits(n_scaled))'(SAMPLE_MIN)) begin
            n_sat = SAMPLE_MIN;
        end else begin
            n_sat = n_scaled[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample_in;
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_mul_a * r_gain[i_cmd.gain_sel];
        end
        if (i_cmd.acc_load) begin
            r_acc <= n_prod_half;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + n_prod_half;
        end
        if (i_cmd.res_load) begin
            r_result <= n_sat;
        end
    end

    assign o_stat.clr_done = r_clr_done;
    assign o_sample_out    = r_result;

endmodule

// File: rtl/mted_ctrl.sv
// Controller state machine that sequences the write, four tap reads and the multiply-accumulate.
`timescale 1ns / 1ps

module mted_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  mted_pkg::t_stat i_stat,
    output mted_pkg::t_cmd  o_cmd
);
    import mted_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_step = '0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_RUN;
                end
            end
            ST_RUN: begin
                n_step = r_step + 1'b1;
                if (r_step == 3'd0) begin
                    o_cmd.wr_we      = 1'b1;
                    o_cmd.mul_en     = 1'b1;
                    o_cmd.mul_src_in = 1'b1;
                    o_cmd.gain_sel   = '0;
                end
                if (r_step >= 3'd1 && r_step <= 3'd4) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.tap   = TAP_W'(r_step - 3'd1);
                end
                if (r_step >= 3'd2 && r_step <= 3'd5) begin
                    o_cmd.mul_en   = 1'b1;
                    o_cmd.gain_sel = GSEL_W'(r_step - 3'd1);
                end
                if (r_step == 3'd1) begin
                    o_cmd.acc_load = 1'b1;
                end
                if (r_step >= 3'd3) begin
                    o_cmd.acc_add = 1'b1;
                end
                if (r_step == 3'd6) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/multitap_echo_delay_top.sv
// Top level of the four-tap echo delay: controller and datapath joined by command and status.
// An accepted item steps through the run state, then waits in the done state until the output
// is free, where the result is registered; input items stay stalled until then, as the single
// memory port (one write and four tap reads) and the shared multiplier serve one item at a time.
// Reset: synchronous, active low; afterward a clearing pass zeroes the delay line, and input items
// stay stalled until the clear state is left; configuration writes are taken throughout.
`timescale 1ns / 1ps

module multitap_echo_delay_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [mted_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [mted_pkg::SAMPLE_W-1:0] o_sample_out,
    input  logic                                 i_cfg_we,
    input  logic [mted_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mted_pkg::CFG_W-1:0]           i_cfg_data
);
    import mted_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    mted_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    mted_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_sample_in  (i_sample_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_sample_out (o_sample_out)
    );

endmodule

// File: sim/multitap_echo_delay_top_tb.sv
// Self-checking testbench for the four-tap echo delay, with its own predictor of the echo mix.
`timescale 1ns / 1ps

module multitap_echo_delay_top_tb;

    import mted_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 150;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic                       out_stall = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = REG_INPUT_GAIN;
    logic [CFG_W-1:0]           cfg_data = '0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic signed [SAMPLE_W-1:0] o_sample_out;

    logic signed [SAMPLE_W-1:0] delay_mem [DEPTH];
    logic [ADDR_W-1:0]          wr_pos;
    logic signed [GAIN_W-1:0]   gain_q [NUM_GAINS];
    logic [CFG_W-1:0]           tap_delay_q;
    logic signed [SAMPLE_W-1:0] pending_echo [$];
    int                         mismatch_count = 0;

    int                         hold_token = 0;
    int                         hold_seen = 0;
    int                         hold_left = 0;
    int                         stall_mode = 0;
    int                         mode_left = 0;
    logic [7:0]                 pat_cnt = '0;

    multitap_echo_delay_top dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_sample_out (o_sample_out),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Stores the sample, advances the write position and returns the saturated echo mix.
    function automatic logic signed [SAMPLE_W-1:0] echo_mix(input logic signed [SAMPLE_W-1:0] x);
        logic [ADDR_W-1:0] w;
        logic [ADDR_W-1:0] rd;
        longint            acc;
        longint            y;
        int                j;
        w = wr_pos;
        delay_mem[w] = x;
        wr_pos = w + 1'b1;
        acc = (longint'(x) * longint'(gain_q[0])) >>> 1;
        for (j = 0; j < NUM_TAPS; j++) begin
            rd = w - tap_delay_q[j*ADDR_W +: ADDR_W];
            acc += (longint'(delay_mem[rd]) * longint'(gain_q[j+1])) >>> 1;
        end
        y = (acc * 2) >>> (GAIN_W - 1);
        if (y > longint'(SAMPLE_MAX)) y = longint'(SAMPLE_MAX);
        if (y < longint'(SAMPLE_MIN)) y = longint'(SAMPLE_MIN);
        return SAMPLE_W'(y);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_q23();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] rand_delay();
        if ($urandom_range(0, 3) == 0) return ADDR_W'($urandom_range(0, DEPTH - 1));
        return ADDR_W'($urandom_range(0, 40));
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        in_valid <= 1'b1;
        sample_in <= s;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        pending_echo.push_back(echo_mix(s));
    endtask

    task automatic pause_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_echo.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input logic [NUM_GAINS*GAIN_W-1:0] gains,
                                 input logic [CFG_W-1:0] delays);
        int k;
        wait_quiet();
        for (k = 0; k < NUM_GAINS; k++) begin
            cfg_we <= 1'b1;
            cfg_index <= REG_INPUT_GAIN + CFG_IDX_W'(k);
            cfg_data <= {GAIN_W'($urandom), gains[k*GAIN_W +: GAIN_W]};
            gain_q[k] = gains[k*GAIN_W +: GAIN_W];
            @(posedge clk);
        end
        cfg_index <= REG_TAP_DELAYS;
        cfg_data <= delays;
        tap_delay_q = delays;
        @(posedge clk);
        // Indexes past the register list must leave every setting untouched.
        for (k = 1; k <= 2; k++) begin
            cfg_index <= REG_TAP_DELAYS + CFG_IDX_W'(k);
            cfg_data <= CFG_W'({$urandom, $urandom});
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample('1);
        send_sample(SAMPLE_W'(1));
        send_sample(SAMPLE_W'(24'h2AAAAA));
        send_sample(SAMPLE_W'(24'h555555));
    endtask

    task automatic test_zero_delay_saturation();
        load_settings({NUM_GAINS{SAMPLE_MAX}}, '0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        load_settings({NUM_GAINS{SAMPLE_MIN}}, '0);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
    endtask

    task automatic test_short_delays();
        int n;
        load_settings({rand_q23(), rand_q23(), rand_q23(), rand_q23(), rand_q23()},
                      {12'd4095, 12'd3, 12'd2, 12'd1});
        for (n = 0; n < 10; n++) send_sample(rand_q23());
    endtask

    task automatic test_receiver_hold();
        int n;
        load_settings({rand_q23(), rand_q23(), rand_q23(), rand_q23(), rand_q23()},
                      {rand_delay(), rand_delay(), rand_delay(), rand_delay()});
        hold_token <= hold_token + 1;
        for (n = 0; n < 24; n++) send_sample(rand_q23());
        wait_quiet();
    endtask

    task automatic test_random_echo();
        int   phase;
        int   n;
        int   burst_left;
        logic no_gaps;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: load_settings({NUM_GAINS{SAMPLE_MAX}}, '1);
                1: load_settings({NUM_GAINS{SAMPLE_MIN}}, '0);
                2: load_settings('0, {rand_delay(), rand_delay(), rand_delay(), rand_delay()});
                default: load_settings({rand_q23(), rand_q23(), rand_q23(), rand_q23(), rand_q23()},
                                       {rand_delay(), rand_delay(), rand_delay(), rand_delay()});
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(1, 20);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_sample(rand_q23());
                if (!no_gaps) begin
                    burst_left--;
                    if (burst_left == 0) begin
                        pause_sender($urandom_range(1, 15));
                        burst_left = $urandom_range(1, 20);
                    end
                end
            end
            if (phase == RANDOM_PHASES / 2) hold_token <= hold_token + 1;
        end
    endtask

    always @(posedge clk) begin
        pat_cnt <= pat_cnt + 1'b1;
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 9) < 3);
                2: out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= (pat_cnt[2:1] == 2'b11);
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid === 1'b1 && !out_stall) begin
            if (pending_echo.size() == 0) begin
                $error("sample_out: unexpected result %0d", o_sample_out);
                mismatch_count++;
            end else if (o_sample_out !== pending_echo[0]) begin
                $error("sample_out mismatch: expected %0d, actual %0d",
                       pending_echo[0], o_sample_out);
                mismatch_count++;
                void'(pending_echo.pop_front());
            end else begin
                void'(pending_echo.pop_front());
            end
        end
    end

    initial begin
        foreach (delay_mem[i]) delay_mem[i] = '0;
        wr_pos = WR_IDX_RESET;
        gain_q = GAIN_RESET;
        tap_delay_q = {DELAY_RESET[3], DELAY_RESET[2], DELAY_RESET[1], DELAY_RESET[0]};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_zero_delay_saturation();
        test_short_delays();
        test_receiver_hold();
        test_random_echo();
        wait_quiet();
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/mted_pkg.sv
rtl/mted_dp.sv
rtl/mted_ctrl.sv
rtl/multitap_echo_delay_top.sv
sim/multitap_echo_delay_top_tb.sv
